### rtl/assert_macros.svh
// Assertion macros shared by the RTL; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define HB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("half-bond trim check failed");

// Next-cycle implication, off while reset is low.
`define HB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("half-bond trim check failed");

`endif

### rtl/hbct_pkg.sv
`timescale 1ns / 1ps
package hbct_pkg;

  // Coordinate and radius fixed-point formats
  localparam int COORD_FRAC_BITS = 16;
  localparam int RAD_FRAC        = 16;
  localparam int SH              = COORD_FRAC_BITS - RAD_FRAC;
  localparam int SHL             = (SH > 0) ? SH : 0;
  localparam int SHR             = (SH < 0) ? -SH : 0;
  // Trim length width in coordinate units, and offset product width
  localparam int TW              = 28 + SHL;
  localparam int NW              = 32 + TW;

  // Pipeline layout
  localparam int SQ_STEPS = 32;
  localparam int DV_STEPS = 32;
  localparam int SQ0      = 3;
  localparam int SQN      = SQ0 + SQ_STEPS;
  localparam int TS       = SQN + 1;
  localparam int DVN      = TS + DV_STEPS;

  // Stream word widths
  localparam int IN_W  = 248;
  localparam int OUT_W = 232;

  // Configuration port
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_STYLE     = 3'd0;
  localparam logic [2:0] REG_BALL      = 3'd1;
  localparam logic [2:0] REG_STICK     = 3'd2;
  localparam logic [2:0] REG_COLOR     = 3'd3;
  localparam logic [2:0] REG_BOND_RGB  = 3'd4;

  localparam logic [1:0] STYLE_SPHERES = 2'd1;
  localparam logic [1:0] STYLE_STICKS  = 2'd2;

  typedef struct packed {
    logic [2:0][31:0] a;
    logic [2:0][31:0] mid;
    logic [2:0][31:0] m;
    logic [2:0]       neg;
    logic [23:0]      rgb;
    logic [7:0]       alpha;
    logic [27:0]      rball;
    logic             drop;
    logic             trim_en;
  } item_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [34:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic [31:0] num;
    logic [32:0] rem;
    logic [31:0] q;
  } dv_t;

  // One digit of the square root: two radicand bits in, one root bit out
  function automatic sq_t sqrt_step(sq_t s);
    sq_t         r;
    logic [34:0] rem2;
    logic [34:0] trial;
    rem2  = {s.rem[32:0], s.rad[63:62]};
    trial = {1'b0, s.root, 2'b01};
    r.rad = {s.rad[61:0], 2'b00};
    if (rem2 >= trial) begin
      r.rem  = rem2 - trial;
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = rem2;
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

  // One quotient bit of restoring division
  function automatic dv_t div_step(dv_t s, logic [31:0] den);
    dv_t         r;
    logic [32:0] rem2;
    rem2  = {s.rem[31:0], s.num[31]};
    r.num = {s.num[30:0], 1'b0};
    if (rem2 >= {1'b0, den}) begin
      r.rem = rem2 - {1'b0, den};
      r.q   = {s.q[30:0], 1'b1};
    end else begin
      r.rem = rem2;
      r.q   = {s.q[30:0], 1'b0};
    end
    return r;
  endfunction

endpackage

### rtl/half_bond_cylinder_trim.sv
`timescale 1ns / 1ps
// Half-bond cylinder trim.
// Input stream: one half-bond word per handshake (atom and partner position,
// van der Waals radius, atom colour and alpha). Output stream: at most one
// cylinder word per input word, from the ball surface to the bond midpoint.
// Words that produce no cylinder (equal positions, spheres-only style,
// zero alpha, half-bond inside the ball) are dropped silently.
// Configuration: APB-style port, registers at byte addresses 0, 4, 8, 12, 16.
// Write registers only while the stream is idle.
// Throughput: one word per cycle while the output is not stalled. Path from
// input handshake to output valid: three front stages, the 32-stage square
// root pipeline (bond length and trim run side by side), the trim compare
// stage, the 32-stage divider for the offsets and the output register.
// Reset (synchronous, active low) empties the pipeline and loads the
// register defaults. When the receiver stalls, the whole pipeline holds and
// in_tready falls until the output word is taken; nothing is lost.
module half_bond_cylinder_trim (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // atom_x, atom_y, atom_z, partner_x, partner_y, partner_z, vdw_radius,
  // atom_rgb, atom_alpha
  input  logic [hbct_pkg::IN_W-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, cyl_rgb, cyl_alpha,
  // transparent
  output logic [hbct_pkg::OUT_W-1:0]  out_tdata,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [hbct_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import hbct_pkg::*;

  logic [1:0]  style_r;
  logic [15:0] ball_scale_r;
  logic [19:0] stick_radius_r;
  logic        color_bonds_r;
  logic [23:0] bond_rgb_r;

  logic        adv;
  logic [DVN:0] vld_r;
  item_t       itm_r [0:DVN];
  logic [2:0][63:0] msq_r;
  logic [55:0] rb2_r;
  logic [39:0] sr2_r;
  sq_t         sqs_r [SQ0:SQN];
  sq_t         sqt_r [SQ0:SQN];
  dv_t         dv_r  [0:2][TS:DVN];
  logic [31:0] len_r [TS:DVN];
  logic        out_tvalid_r;
  logic [OUT_W-1:0] out_tdata_r;

  item_t       s0, s1, s2, sts;
  logic        kill;
  logic [TW-1:0] tval;
  logic [2:0][NW-1:0] pm;
  logic [2:0][31:0] st;

  // Configuration registers
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      style_r        <= 2'd0;
      ball_scale_r   <= 16'd256;
      stick_radius_r <= 20'd9830;
      color_bonds_r  <= 1'b1;
      bond_rgb_r     <= 24'h808080;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[4:2])
        REG_STYLE:    style_r        <= cfg_pwdata[1:0];
        REG_BALL:     ball_scale_r   <= cfg_pwdata[15:0];
        REG_STICK:    stick_radius_r <= cfg_pwdata[19:0];
        REG_COLOR:    color_bonds_r  <= cfg_pwdata[0];
        REG_BOND_RGB: bond_rgb_r     <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_STYLE:    cfg_prdata = {30'd0, style_r};
      REG_BALL:     cfg_prdata = {16'd0, ball_scale_r};
      REG_STICK:    cfg_prdata = {12'd0, stick_radius_r};
      REG_COLOR:    cfg_prdata = {31'd0, color_bonds_r};
      REG_BOND_RGB: cfg_prdata = {8'd0, bond_rgb_r};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  // Advance the whole pipeline unless the output word is stalled
  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;

  // Stage 0: midpoint, drop checks, ball radius
  always_comb begin
    logic        same;
    logic [32:0] sum;
    logic [35:0] prod;
    s0   = '0;
    same = 1'b1;
    for (int i = 0; i < 3; i++) begin
      sum = {in_tdata[32*i+31], in_tdata[32*i +: 32]}
          + {in_tdata[96+32*i+31], in_tdata[96+32*i +: 32]};
      s0.a[i]   = in_tdata[32*i +: 32];
      s0.mid[i] = sum[32:1];
      if (in_tdata[32*i +: 32] != in_tdata[96+32*i +: 32]) same = 1'b0;
    end
    prod     = {16'd0, in_tdata[211:192]} * {20'd0, ball_scale_r};
    s0.rball = (style_r == STYLE_STICKS) ? {8'd0, stick_radius_r} : prod[35:8];
    s0.drop  = same || (style_r == STYLE_SPHERES) || (in_tdata[243:236] == 8'd0);
    s0.rgb   = color_bonds_r ? in_tdata[235:212] : bond_rgb_r;
    s0.alpha = in_tdata[243:236];
  end

  // Stage 1: half-bond vector as sign and magnitude
  always_comb begin
    logic [32:0] d;
    s1 = itm_r[0];
    for (int i = 0; i < 3; i++) begin
      d         = {itm_r[0].mid[i][31], itm_r[0].mid[i]}
                - {itm_r[0].a[i][31], itm_r[0].a[i]};
      s1.neg[i] = d[32];
      s1.m[i]   = d[32] ? 32'(-d) : d[31:0];
    end
  end

  // Stage 2: trim applies only when the ball is wider than the stick
  always_comb begin
    s2         = itm_r[1];
    s2.trim_en = itm_r[1].rball > {8'd0, stick_radius_r};
  end

  // Trim stage: bond length against trim, offset products
  always_comb begin
    logic [27:0] trim;
    trim = sqt_r[SQN].root[27:0];
    if (SH >= 0) tval = TW'(trim) << SHL;
    else         tval = TW'(trim >> SHR);
    kill = itm_r[TS-1].trim_en && (64'(sqs_r[SQN].root) <= 64'(tval));
    for (int i = 0; i < 3; i++) begin
      pm[i] = NW'(itm_r[TS-1].m[i]) * NW'(tval);
    end
    sts      = itm_r[TS-1];
    sts.drop = itm_r[TS-1].drop || kill;
  end

  // Output: pull the start point in by the signed offset
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!itm_r[DVN].trim_en)  st[i] = itm_r[DVN].a[i];
      else if (itm_r[DVN].neg[i]) st[i] = itm_r[DVN].a[i] - dv_r[i][DVN].q;
      else                        st[i] = itm_r[DVN].a[i] + dv_r[i][DVN].q;
    end
  end

  // Valid bits travel with the words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      vld_r        <= {vld_r[DVN-1:0], in_tvalid};
      out_tvalid_r <= vld_r[DVN] && !itm_r[DVN].drop;
    end
  end

  // Payload pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      itm_r[0] <= s0;
      itm_r[1] <= s1;
      itm_r[2] <= s2;
      for (int i = 0; i < 3; i++) begin
        msq_r[i] <= 64'(itm_r[1].m[i]) * 64'(itm_r[1].m[i]);
      end
      rb2_r <= 56'(itm_r[1].rball) * 56'(itm_r[1].rball);
      sr2_r <= 40'(stick_radius_r) * 40'(stick_radius_r);
      for (int k = 3; k <= DVN; k++) begin
        if (k == TS) itm_r[k] <= sts;
        else         itm_r[k] <= itm_r[k-1];
      end

      // square roots of squared length and of rBall^2 - rStick^2
      sqs_r[SQ0] <= '{rad: msq_r[0] + msq_r[1] + msq_r[2], rem: '0, root: '0};
      sqt_r[SQ0] <= '{rad: {8'd0, rb2_r - 56'(sr2_r)}, rem: '0, root: '0};
      for (int k = SQ0 + 1; k <= SQN; k++) begin
        sqs_r[k] <= sqrt_step(sqs_r[k-1]);
        sqt_r[k] <= sqrt_step(sqt_r[k-1]);
      end

      // divide each offset product by the length
      len_r[TS] <= sqs_r[SQN].root;
      for (int i = 0; i < 3; i++) begin
        dv_r[i][TS] <= '{num: pm[i][31:0], rem: 33'(pm[i] >> 32), q: '0};
      end
      for (int k = TS + 1; k <= DVN; k++) begin
        len_r[k] <= len_r[k-1];
        for (int i = 0; i < 3; i++) begin
          dv_r[i][k] <= div_step(dv_r[i][k-1], len_r[k-1]);
        end
      end

      out_tdata_r <= {7'd0, (itm_r[DVN].alpha != 8'hFF), itm_r[DVN].alpha,
                      itm_r[DVN].rgb, itm_r[DVN].mid[2], itm_r[DVN].mid[1],
                      itm_r[DVN].mid[0], st[2], st[1], st[0]};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`include "assert_macros.svh"

  `HB_ASSERT_NXT(a_hold_on_stall, !adv, $stable(vld_r))
  `HB_ASSERT_IMP(a_alpha_nonzero, out_tvalid, out_tdata[223:216] != 8'd0)
  `HB_ASSERT_IMP(a_transparent, out_tvalid,
                 out_tdata[224] == (out_tdata[223:216] != 8'hFF))
  `HB_ASSERT_IMP(a_len_nonzero,
                 vld_r[TS] && itm_r[TS].trim_en && !itm_r[TS].drop,
                 len_r[TS] != 32'd0)

endmodule

### tb/sv/half_bond_cylinder_trim_tb.sv
`timescale 1ns / 1ps

module half_bond_cylinder_trim_tb;
  import hbct_pkg::*;

  // Expected cylinder word, fields in out_tdata order (lowest field first)
  typedef struct {
    logic [31:0] sx, sy, sz, ex, ey, ez;
    logic [23:0] rgb;
    logic [7:0]  alpha;
    logic        transp;
  } cyl_t;

  class cyl_scoreboard;
    cyl_t pending[$];
    int   errors;

    // Register copies
    logic [1:0]  style;
    logic [15:0] ball;
    logic [19:0] stick;
    logic        colored;
    logic [23:0] bond_rgb;

    function new();
      errors = 0;
      style = 2'd0; ball = 16'd256; stick = 20'd9830; colored = 1'b1;
      bond_rgb = 24'h808080;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_STYLE:    style = v[1:0];
        REG_BALL:     ball = v[15:0];
        REG_STICK:    stick = v[19:0];
        REG_COLOR:    colored = v[0];
        REG_BOND_RGB: bond_rgb = v[23:0];
        default: ;
      endcase
    endfunction

    // Integer floor square root of a value below 2^70
    function automatic logic [35:0] isqrt(logic [69:0] s);
      logic [35:0]  r;
      logic [35:0]  c;
      r = 0;
      for (int b = 35; b >= 0; b--) begin
        c = r | (36'd1 << b);
        if ({36'd0, c} * {36'd0, c} <= {2'd0, s}) r = c;
      end
      return r;
    endfunction

    // Work out the cylinder for one accepted half-bond word
    function void note_half_bond(logic [IN_W-1:0] w);
      logic signed [33:0] a[3], b[3], mid[3], d[3], st[3];
      logic [69:0] s;
      logic [63:0] rball, srad, diff, t, len, m, off;
      logic [19:0] vdw;
      logic [7:0]  alpha;
      logic        same;
      cyl_t        c;
      same = 1;
      for (int i = 0; i < 3; i++) begin
        a[i] = 34'($signed(w[32*i +: 32]));
        b[i] = 34'($signed(w[32*(i+3) +: 32]));
        if (a[i] != b[i]) same = 0;
        mid[i] = (a[i] + b[i]) >>> 1;
        d[i] = mid[i] - a[i];
        st[i] = a[i];
      end
      vdw = w[192 +: 20];
      alpha = w[236 +: 8];
      if (same || style == STYLE_SPHERES || alpha == 0) return;
      srad = 64'(stick);
      rball = (style == STYLE_STICKS) ? srad : ((64'(vdw) * 64'(ball)) >> 8);
      if (rball > srad) begin
        diff = rball * rball - srad * srad;
        t = 64'(isqrt({6'd0, diff}));
        s = 0;
        for (int i = 0; i < 3; i++) begin
          m = 64'((d[i] < 0) ? -d[i] : d[i]);
          s = s + 70'(m) * 70'(m);
        end
        len = 64'(isqrt(s));
        if (len <= t) return;
        for (int i = 0; i < 3; i++) begin
          m = 64'((d[i] < 0) ? -d[i] : d[i]);
          off = (m * t) / len;
          st[i] = (d[i] < 0) ? a[i] - $signed({1'b0, off[32:0]})
                             : a[i] + $signed({1'b0, off[32:0]});
        end
      end
      c.sx = st[0][31:0]; c.sy = st[1][31:0]; c.sz = st[2][31:0];
      c.ex = mid[0][31:0]; c.ey = mid[1][31:0]; c.ez = mid[2][31:0];
      c.rgb = colored ? w[212 +: 24] : bond_rgb;
      c.alpha = alpha;
      c.transp = (alpha != 8'd255);
      pending.insert(pending.size(), c);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    task check_cylinder(logic [OUT_W-1:0] w);
      cyl_t c;
      if (pending.size() == 0) begin
        report("unexpected word", w[31:0], 32'd0);
        return;
      end
      c = pending.pop_front();
      if (w[0 +: 32] !== c.sx) report("start_x", w[0 +: 32], c.sx);
      if (w[32 +: 32] !== c.sy) report("start_y", w[32 +: 32], c.sy);
      if (w[64 +: 32] !== c.sz) report("start_z", w[64 +: 32], c.sz);
      if (w[96 +: 32] !== c.ex) report("end_x", w[96 +: 32], c.ex);
      if (w[128 +: 32] !== c.ey) report("end_y", w[128 +: 32], c.ey);
      if (w[160 +: 32] !== c.ez) report("end_z", w[160 +: 32], c.ez);
      if (w[192 +: 24] !== c.rgb)
        report("cyl_rgb", 32'(w[192 +: 24]), 32'(c.rgb));
      if (w[216 +: 8] !== c.alpha)
        report("cyl_alpha", 32'(w[216 +: 8]), 32'(c.alpha));
      if (w[224] !== c.transp)
        report("transparent", 32'(w[224]), 32'(c.transp));
    endtask
  endclass

  logic              clk = 0;
  logic              rst_n = 0;
  logic              in_tvalid = 0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 0;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  cyl_scoreboard cylinders = new();
  int  cycle = 0;
  bit  calm = 0;
  int  accepted = 0;
  localparam int LIMIT = 400000;

  half_bond_cylinder_trim dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("half_bond_cylinder_trim_tb: done, errors");
      $finish;
    end
  end

  // Sample both handshakes
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      cylinders.note_half_bond(in_tdata);
      accepted++;
    end
    if (rst_n && out_tvalid && out_tready) cylinders.check_cylinder(out_tdata);
  end

  // Receiver stalls in random bursts, none in the calm tail
  initial begin
    int n;
    @(negedge clk);
    forever begin
      out_tready <= 1;
      n = $urandom_range(1, 40);
      repeat (n) @(negedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_tready <= 0;
        n = $urandom_range(1, 19);
        repeat (n) @(negedge clk);
      end
    end
  end

  task write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= ADDR_W'(idx) << 2; cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cylinders.set_reg(idx, v);
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  // Send one half-bond word, with an optional idle burst first
  task send(logic [IN_W-1:0] w);
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 0;
      n = $urandom_range(1, 19);
      repeat (n) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [IN_W-1:0] pack(logic [2:0][31:0] a, logic [2:0][31:0] p,
                                           logic [19:0] r, logic [23:0] rgb,
                                           logic [7:0] al);
    return {4'd0, al, rgb, r, p, a};
  endfunction

  function automatic logic [31:0] rnd32();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
                                    : 32'h80000000 + $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
    endcase
  endfunction

  // Mostly nearby partners so lengths straddle the trim
  function automatic logic [IN_W-1:0] rand_bond();
    logic [2:0][31:0] a, p;
    logic [19:0] r;
    logic [7:0]  al;
    int          k;
    k = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      a[i] = rnd32();
      if (k < 7) p[i] = a[i] + ($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      else if (k == 7) p[i] = a[i];
      else p[i] = rnd32();
    end
    r = ($urandom_range(0, 4) == 0) ? 20'($urandom)
                                    : 20'($urandom_range(40000, 150000));
    case ($urandom_range(0, 5))
      0: al = 8'd0;
      1: al = 8'd255;
      default: al = 8'($urandom);
    endcase
    return pack(a, p, r, 24'($urandom), al);
  endfunction

  task drain();
    int waited;
    in_tvalid <= 0;
    waited = 0;
    while (cylinders.pending.size() != 0 && waited < 100000) begin
      @(negedge clk);
      waited++;
    end
    repeat (120) @(negedge clk);
  endtask

  initial begin
    logic [2:0][31:0] z, one, big, neg;
    z = '0;
    one = '{32'd0, 32'd0, 32'h00010000};
    big = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
    neg = '{32'h80000000, 32'h80000000, 32'h80000000};
    repeat (12) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: extremes, drops and zero-length cases under reset settings
    send(pack(z, z, 20'd65536, 24'h123456, 8'd255));           // equal positions
    send(pack(z, one, 20'd65536, 24'h123456, 8'd0));           // zero alpha
    send(pack(z, one, 20'd0, 24'hffffff, 8'd255));             // zero radius
    send(pack(z, one, 20'hfffff, 24'h000000, 8'd128));         // inside the ball
    send(pack(z, '{32'd0, 32'd0, 32'h00100000}, 20'd65536, 24'habcdef, 8'd1));
    send(pack(big, neg, 20'd70000, 24'h0f0f0f, 8'd254));
    send(pack(neg, big, 20'd70000, 24'hf0f0f0, 8'd255));
    send(pack(neg, '{32'h80000000, 32'h80000000, 32'h80000001}, 20'd0,
              24'h555555, 8'd255));                            // midpoint on atom
    send(pack(big, neg, 20'hfffff, 24'haaaaaa, 8'd255));
    drain();

    // Walk several register settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(REG_STYLE, 0); write_reg(REG_BALL, 16'hffff);
                 write_reg(REG_STICK, 0); write_reg(REG_COLOR, 0);
                 write_reg(REG_BOND_RGB, 32'hffffffff); end
        1: begin write_reg(REG_STYLE, STYLE_SPHERES); end
        2: begin write_reg(REG_STYLE, STYLE_STICKS); write_reg(REG_STICK, 20'hfffff);
                 write_reg(REG_BOND_RGB, 0); end
        3: begin write_reg(REG_STYLE, 3); write_reg(REG_BALL, 0);
                 write_reg(REG_STICK, 9830); end
        4: begin write_reg(REG_STYLE, 0); write_reg(REG_BALL, 128);
                 write_reg(REG_COLOR, 1); end
        5: begin write_reg(REG_BALL, $urandom_range(64, 1024));
                 write_reg(REG_STICK, $urandom_range(0, 60000));
                 write_reg(REG_BOND_RGB, $urandom); end
        6: begin write_reg(REG_BALL, 256); write_reg(REG_STICK, 9830);
                 write_reg(REG_COLOR, 1); end
        default: begin write_reg(REG_STYLE, 0); write_reg(REG_COLOR, 0);
                 calm = 1; end
      endcase
      for (int i = 0; i < (ph == 1 ? 60 : 240); i++) send(rand_bond());
      drain();
    end

    if (cylinders.errors == 0)
      $display("half_bond_cylinder_trim_tb: done, clean");
    else
      $display("half_bond_cylinder_trim_tb: done, errors");
    $finish;
  end
endmodule

### sim.f
+incdir+rtl
rtl/hbct_pkg.sv
rtl/half_bond_cylinder_trim.sv
tb/sv/half_bond_cylinder_trim_tb.sv
